// File: src/b64se_pkg.sv
// Package for the Base64 stream encoder: the phase type, the queue entry type,
// character constants and the six-bit symbol to ASCII mapping.
// Depends on nothing; the modules in src import it.
package b64se_pkg;

  // Position of the next byte within a three-byte group.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam int CharW  = 7;
  localparam int Slots  = 4;

  localparam logic [CharW-1:0] CHAR_PAD   = 7'h3D; // '='
  localparam logic [CharW-1:0] CHAR_PLUS  = 7'h2B; // '+'
  localparam logic [CharW-1:0] CHAR_SLASH = 7'h2F; // '/'
  localparam logic [CharW-1:0] OFS_UPPER  = 7'd65; // 'A'
  localparam logic [CharW-1:0] OFS_LOWER  = 7'd71; // 'a' minus 26
  localparam logic [CharW-1:0] OFS_DIGIT  = 7'd4;  // 52 minus '0'

  // One classified byte: up to four characters, the index of the final one
  // and whether that final character closes the message.
  typedef struct packed {
    logic [Slots-1:0][CharW-1:0] chars;
    logic [1:0]                  cnt;
    logic                        last;
  } entry_t;

  // Maps a six-bit symbol onto the standard alphabet.
  function automatic logic [CharW-1:0] sym(input logic [5:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return OFS_UPPER + v7;
    end else if (v < 6'd52) begin
      return OFS_LOWER + v7;
    end else if (v < 6'd62) begin
      return v7 - OFS_DIGIT;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

// File: src/b64se_in_if.sv
// Byte channel of the Base64 stream encoder: valid/ready with byte and end flag.
// Depends on nothing.
interface b64se_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/b64se_out_if.sv
// Character channel of the Base64 stream encoder: valid/ready with ASCII code
// and end flag. Depends on nothing.
interface b64se_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// File: src/b64se_front.sv
// Front part of the Base64 stream encoder: accepts bytes, tracks the group
// phase and leftover bits, and turns each byte into a queue entry.
// Depends on b64se_pkg.
module b64se_front
  import b64se_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_entry
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Classify the byte by its phase and build the characters it causes.
  always_comb begin
    push_entry       = '0;
    push_entry.last  = in_last;
    phase_nxt        = phase_r;
    carry_nxt        = carry_r;
    unique case (phase_r)
      PH_SECOND: begin
        push_entry.chars[0] = sym({carry_r[1:0], in_byte[7:4]});
        push_entry.chars[1] = sym({in_byte[3:0], 2'b00});
        push_entry.chars[2] = CHAR_PAD;
        push_entry.cnt      = in_last ? 2'd2 : 2'd0;
        phase_nxt           = PH_THIRD;
        carry_nxt           = in_byte[3:0];
      end
      PH_THIRD: begin
        push_entry.chars[0] = sym({carry_r, in_byte[7:6]});
        push_entry.chars[1] = sym(in_byte[5:0]);
        push_entry.cnt      = 2'd1;
        phase_nxt           = PH_FIRST;
        carry_nxt           = 4'd0;
      end
      default: begin
        push_entry.chars[0] = sym(in_byte[7:2]);
        push_entry.chars[1] = sym({in_byte[1:0], 4'b0000});
        push_entry.chars[2] = CHAR_PAD;
        push_entry.chars[3] = CHAR_PAD;
        push_entry.cnt      = in_last ? 2'd3 : 2'd0;
        phase_nxt           = PH_SECOND;
        carry_nxt           = {2'b00, in_byte[1:0]};
      end
    endcase
    // The final byte of a message returns the encoder to a group start.
    if (in_last) begin
      phase_nxt = PH_FIRST;
      carry_nxt = 4'd0;
    end
  end

  // Phase and leftover bits advance on every byte transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// File: src/b64se_queue.sv
// Short queue of classified entries between the front and back parts.
// Depends on b64se_pkg.
module b64se_queue
  import b64se_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_r [Depth];
  logic [IdxW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: src/b64se_back.sv
// Back part of the Base64 stream encoder: takes queue entries and sends their
// characters one per cycle, while the output is taken, through an output register. Depends on b64se_pkg.
module b64se_back
  import b64se_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  entry_t           pop_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char,
  output logic             out_last
);

  entry_t           cur_r, cur_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             advance;
  logic             at_end;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign advance   = !out_valid_r || out_ready;
  assign at_end    = (idx_r == cur_r.cnt);
  // A new entry is taken when idle or as the last character leaves.
  assign pop_ready = !busy_r || (advance && at_end);

  always_comb begin
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    // Move the next character into the output register when it is free.
    if (advance) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_char_nxt = cur_r.chars[idx_r];
        out_last_nxt = cur_r.last && at_end;
        idx_nxt      = idx_r + 1'b1;
      end
    end
    // Load the following entry straight behind the current one.
    if (pop_ready) begin
      busy_nxt = pop_valid;
      if (pop_valid) begin
        cur_nxt = pop_entry;
        idx_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: src/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front classifier, entry queue and
// character sender. Depends on b64se_pkg, the two channel interfaces and the
// b64se_front, b64se_queue and b64se_back modules.
//
//   Channel | Direction | Payload             | Handshake
//   in_s    | input     | in_byte, in_last    | valid / ready
//   out_s   | output    | out_char, out_last  | valid / ready
//
// One character leaves per cycle while the output is taken; the single output
// register limits the stream rate. The front is combinational, so a byte enters
// the queue at its own transfer edge. Its first character then passes through
// the entry register of the back part and the output register.
// Synchronous active-low reset empties the queue and returns to a group start.
// Output stalls fill the queue, after which the input ready drops.
module base64_stream_encoder
  import b64se_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst_n,
  b64se_in_if.sink   in_s,
  b64se_out_if.source out_s
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  b64se_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_s.valid),
    .in_ready   (in_s.ready),
    .in_byte    (in_s.in_byte),
    .in_last    (in_s.in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  b64se_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_char  (out_s.out_char),
    .out_last  (out_s.out_last)
  );

endmodule

// File: src/b64se_checker.sv
// Port-level checks for the Base64 stream encoder and the bind that attaches
// them to the top level. Depends on b64se_pkg and base64_stream_encoder.
module b64se_checker
  import b64se_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CharW-1:0] out_char,
  input logic             out_last
);

  // A stalled character keeps its code and end flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output character changed");

  // Only alphabet characters and padding are ever shown.
  a_out_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 7'h41 && out_char <= 7'h5A) ||
                  (out_char >= 7'h61 && out_char <= 7'h7A) ||
                  (out_char >= 7'h30 && out_char <= 7'h39) ||
                  out_char == CHAR_PLUS || out_char == CHAR_SLASH ||
                  out_char == CHAR_PAD)
    else $error("output character outside the Base64 alphabet");

  // Reset leaves no character pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // Reset leaves the queue empty, so a byte can be taken at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_char  (out_s.out_char),
  .out_last  (out_s.out_last)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Base64 stream encoder: directed messages, then random
// messages under random stalls on both channels. Depends on b64se_pkg, the two channel
// interfaces and base64_stream_encoder.
module testbench;
  import b64se_pkg::*;

  localparam int TOTAL_ITEMS  = 460;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS   = 500_000;
  localparam int N_DIRECTED   = 23;

  // Standard alphabet, symbol 0 in the top byte.
  localparam logic [8*64-1:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                          "abcdefghijklmnopqrstuvwxyz",
                                          "0123456789+/"};

  // One byte to send; a non-zero char_n means the characters are typed in txt.
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  char_n;
    logic [31:0] txt;
  } byte_item_t;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             fin;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64se_in_if  in_if ();
  b64se_out_if out_if ();

  base64_stream_encoder u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if)
  );

  // Predictor state and the characters still awaited on the output.
  phase_t     enc_phase;
  logic [3:0] enc_carry;
  enc_char_t  enc_out [4];
  int         enc_cnt;
  enc_char_t  pending_chars [$];

  byte_item_t directed_rows [0:N_DIRECTED-1];
  byte_item_t byte_plan [$];

  int error_count    = 0;
  int bytes_accepted = 0;
  bit calm           = 1'b0;
  bit held_off       = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reports one mismatch on a line of its own and counts it.
  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [CharW-1:0] alphabet_char(input logic [5:0] v);
    return ALPHABET[(63 - v) * 8 +: CharW];
  endfunction

  function automatic void stage_char(input logic [CharW-1:0] c, input logic f);
    enc_out[enc_cnt] = '{code: c, fin: f};
    enc_cnt++;
  endfunction

  // Works out the characters that one byte produces and advances the group state.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    enc_cnt = 0;
    case (enc_phase)
      PH_SECOND: begin
        stage_char(alphabet_char({enc_carry[1:0], b[7:4]}), 1'b0);
        enc_carry = b[3:0];
        enc_phase = PH_THIRD;
        if (fin) begin
          stage_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
          stage_char(CHAR_PAD, 1'b1);
        end
      end
      PH_THIRD: begin
        stage_char(alphabet_char({enc_carry, b[7:6]}), 1'b0);
        stage_char(alphabet_char(b[5:0]), fin);
        enc_carry = 4'd0;
        enc_phase = PH_FIRST;
      end
      default: begin
        stage_char(alphabet_char(b[7:2]), 1'b0);
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PH_SECOND;
        if (fin) begin
          stage_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
          stage_char(CHAR_PAD, 1'b0);
          stage_char(CHAR_PAD, 1'b1);
        end
      end
    endcase
    // The final byte always returns the encoder to the start of a group.
    if (fin) begin
      enc_phase = PH_FIRST;
      enc_carry = 4'd0;
    end
  endfunction

  // Directed messages: the final byte at each group position, all-zero and all-one
  // bytes, a textbook group, and zero bytes inside a message.
  initial begin
    directed_rows = '{
      '{8'h00, 1'b1, 3'd4, "AA=="},
      '{8'hFF, 1'b1, 3'd4, "/w=="},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd3, "AA="},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd3, "/8="},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd2, "AA"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd2, "//"},
      '{8'h4D, 1'b0, 3'd1, "T"},
      '{8'h61, 1'b0, 3'd1, "W"},
      '{8'h6E, 1'b1, 3'd2, "Fu"},
      '{8'h80, 1'b0, 3'd0, 32'd0},
      '{8'h01, 1'b0, 3'd0, 32'd0},
      '{8'h7F, 1'b0, 3'd0, 32'd0},
      '{8'hFE, 1'b0, 3'd0, 32'd0},
      '{8'h55, 1'b1, 3'd0, 32'd0},
      '{8'h41, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 3'd0, 32'd0},
      '{8'h42, 1'b1, 3'd0, 32'd0}
    };
  end

  // Sender: builds the plan, releases reset, then offers one byte per transfer.
  initial begin : byte_source
    byte_item_t item;
    int         msg_len;
    int         i;
    int         j;

    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.in_last <= 1'b0;
    enc_phase = PH_FIRST;
    enc_carry = 4'd0;

    #0;
    for (i = 0; i < N_DIRECTED; i++) begin
      byte_plan.push_back(directed_rows[i]);
    end
    // Random messages, mostly short, now and then a long one.
    while (byte_plan.size() < TOTAL_ITEMS) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (j = 0; j < msg_len; j++) begin
        case ($urandom_range(0, 9))
          0:       item.data = 8'h00;
          1:       item.data = 8'hFF;
          default: item.data = 8'($urandom_range(0, 255));
        endcase
        item.fin    = (j == msg_len - 1);
        item.char_n = 3'd0;
        item.txt    = 32'd0;
        byte_plan.push_back(item);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < byte_plan.size(); i++) begin
      item = byte_plan[i];
      calm = (i >= byte_plan.size() - CALM_ITEMS);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_if.valid   <= 1'b1;
      in_if.in_byte <= item.data;
      in_if.in_last <= item.fin;
      do @(posedge clk); while (!in_if.ready);

      // The byte transferred at this edge.
      bytes_accepted++;
      encode_byte(item.data, item.fin);
      if (item.char_n != 3'd0) begin
        for (j = 0; j < item.char_n; j++) begin
          pending_chars.push_back('{code: item.txt[(item.char_n - 1 - j) * 8 +: CharW],
                                    fin: item.fin && (j == item.char_n - 1)});
        end
      end else begin
        for (j = 0; j < enc_cnt; j++) begin
          pending_chars.push_back(enc_out[j]);
        end
      end
    end
    in_if.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back the encoder up, none at the end.
  initial begin : char_sink
    forever begin
      if (!held_off && bytes_accepted >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Each character transfer is compared with the oldest awaited character.
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        report_error($sformatf("unexpected character 0x%02h last %0b",
                               out_if.out_char, out_if.out_last));
      end else begin
        want = pending_chars.pop_front();
        if (out_if.out_char !== want.code) begin
          report_error($sformatf("character 0x%02h, expected 0x%02h",
                                 out_if.out_char, want.code));
        end
        if (out_if.out_last !== want.fin) begin
          report_error($sformatf("last flag %0b, expected %0b on character 0x%02h",
                                 out_if.out_last, want.fin, want.code));
        end
      end
    end
  end

  // Guards against a hang; generous against the slowest legal run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: sim.f
src/b64se_pkg.sv
src/b64se_in_if.sv
src/b64se_out_if.sv
src/b64se_front.sv
src/b64se_queue.sv
src/b64se_back.sv
src/base64_stream_encoder.sv
src/b64se_checker.sv
tb/testbench.sv
